@@ src/lpkv_pkg.sv @@
// Shared constants, codes and types for the linear-probe key/value table.
// No dependencies; compiled before the interfaces and the table itself.
`default_nettype none

package lpkv_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  localparam int REQ_W    = 2;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef logic [IDX_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_entry_t;

endpackage

`default_nettype wire

@@ src/lpkv_if.sv @@
// Valid/ready channel interfaces for the request and response sides of the table.
// Depends on lpkv_pkg for field widths.
`default_nettype none

interface lpkv_req_if;
  import lpkv_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [KEY_W-1:0]    key;
  logic [VAL_W-1:0]    value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lpkv_rsp_if;
  import lpkv_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

`default_nettype wire

@@ src/linear_probe_key_value_table.sv @@
// Fixed-capacity key/value table with open addressing and linear probing.
// Depends on lpkv_pkg and the channel interfaces in lpkv_if.sv.
//
// One request at a time. Keys and values sit in a slot memory with one write port and a
// registered read port; valid bits are flip-flops cleared by reset. An insert probes
// from slot key mod TABLE_SLOTS using the valid bits only, one slot per cycle. Lookup
// and remove scan the memory from slot 0, one read per cycle through its single read
// port, and stop at the first match or after the last slot. A request code of 3 goes
// straight to the response. The response is held in an output register, so the next
// request is taken while the previous response waits. TABLE_SLOTS is a power of two.
`default_nettype none

module linear_probe_key_value_table (
  input  logic       clk,
  input  logic       rst_n,
  lpkv_req_if.sink   in_req,
  lpkv_rsp_if.source out_rsp
);
  import lpkv_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INSERT = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(TABLE_SLOTS - 1);

  logic [1:0]             state_r, state_nxt;
  logic [TABLE_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [VAL_W-1:0]       val_r, val_nxt;
  slot_idx_t              pos_r, pos_nxt;
  slot_idx_t              cnt_r, cnt_nxt;
  slot_idx_t              scan_idx_r, scan_idx_nxt;
  slot_idx_t              chk_idx_r, chk_idx_nxt;
  logic                   issue_on_r, issue_on_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [VAL_W-1:0]       res_value_r, res_value_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [VAL_W-1:0]       out_value_r, out_value_nxt;

  slot_entry_t slot_mem [TABLE_SLOTS];
  slot_entry_t rd_entry_r;
  logic        mem_we;
  logic        hit;
  logic        out_free;

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.found_value = out_value_r;

  assign out_free = !out_valid_r || out_rsp.ready;
  assign hit      = chk_v_r && slot_valid_r[chk_idx_r] && (rd_entry_r.key == key_r);

  always_comb begin
    state_nxt      = state_r;
    slot_valid_nxt = slot_valid_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    chk_idx_nxt    = chk_idx_r;
    issue_on_nxt   = issue_on_r;
    chk_v_nxt      = chk_v_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt        = in_req.req_type;
          key_nxt        = in_req.key;
          val_nxt        = in_req.value;
          pos_nxt        = in_req.key[IDX_W-1:0];
          cnt_nxt        = '0;
          scan_idx_nxt   = '0;
          issue_on_nxt   = 1'b0;
          chk_v_nxt      = 1'b0;
          res_status_nxt = STATUS_NOT_FOUND;
          res_value_nxt  = '0;
          case (in_req.req_type)
            REQ_INSERT: begin
              state_nxt = S_INSERT;
            end
            REQ_LOOKUP, REQ_REMOVE: begin
              state_nxt    = S_SCAN;
              issue_on_nxt = 1'b1;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_INSERT: begin
        if (!slot_valid_r[pos_r]) begin
          mem_we                = 1'b1;
          slot_valid_nxt[pos_r] = 1'b1;
          res_status_nxt        = STATUS_OK;
          state_nxt             = S_RESP;
        end else if (cnt_r == LAST_SLOT) begin
          res_status_nxt = STATUS_FULL;
          state_nxt      = S_RESP;
        end else begin
          pos_nxt = pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        chk_v_nxt   = issue_on_r;
        chk_idx_nxt = scan_idx_r;
        if (issue_on_r) begin
          if (scan_idx_r == LAST_SLOT) begin
            issue_on_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (hit) begin
          res_status_nxt = STATUS_OK;
          if (req_r == REQ_LOOKUP) begin
            res_value_nxt = rd_entry_r.value;
          end else begin
            slot_valid_nxt[chk_idx_r] = 1'b0;
          end
          issue_on_nxt = 1'b0;
          chk_v_nxt    = 1'b0;
          state_nxt    = S_RESP;
        end else if (chk_v_r && chk_idx_r == LAST_SLOT) begin
          chk_v_nxt = 1'b0;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      issue_on_r   <= 1'b0;
      chk_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      issue_on_r   <= issue_on_nxt;
      chk_v_r      <= chk_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    scan_idx_r   <= scan_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[pos_r] <= '{key: key_r, value: val_r};
    end
    rd_entry_r <= slot_mem[scan_idx_r];
  end

`ifndef SYNTHESIS
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT && !slot_valid_r[pos_r]) |=> slot_valid_r[$past(pos_r)])
    else $error("insert did not mark its slot valid");

  a_remove_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit && req_r == REQ_REMOVE) |=> !slot_valid_r[$past(chk_idx_r)])
    else $error("remove did not clear the matching slot");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_status_r == STATUS_FULL) |-> (&slot_valid_r))
    else $error("table full reported with a free slot");

  a_zero_value_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |-> (out_value_r == '0))
    else $error("non-zero value on a failed request");

  a_idle_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> (!chk_v_r && !issue_on_r))
    else $error("scan pipeline busy while taking a request");
`endif

endmodule

`default_nettype wire

@@ test/linear_probe_key_value_table_test.sv @@
// Self-checking testbench for linear_probe_key_value_table: insert, lookup and remove
// requests are predicted against a behavioural slot table and every response is checked.
// Depends on lpkv_pkg and the channel interfaces in lpkv_if.sv.
`timescale 1ns / 1ps

module linear_probe_key_value_table_test;
  import lpkv_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 400;
  localparam int POOL_KEYS = 24;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
  } answer_t;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   errors = 0;

  request_t pending_requests[$];
  answer_t  expected_answers[$];

  bit               table_valid[TABLE_SLOTS];
  logic [KEY_W-1:0] table_key[TABLE_SLOTS];
  logic [VAL_W-1:0] table_value[TABLE_SLOTS];

  lpkv_req_if in_req();
  lpkv_rsp_if out_rsp();

  linear_probe_key_value_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  function automatic answer_t apply_request(request_t r);
    answer_t   a;
    slot_idx_t pos;
    int        hit;
    a.status = STATUS_NOT_FOUND;
    a.found_value = '0;
    hit = -1;
    if (r.req_type == REQ_INSERT) begin
      a.status = STATUS_FULL;
      pos = r.key[IDX_W-1:0];
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (!table_valid[pos]) begin
          table_valid[pos] = 1'b1;
          table_key[pos] = r.key;
          table_value[pos] = r.value;
          a.status = STATUS_OK;
          break;
        end
        pos = pos + 1'b1;
      end
    end else if (r.req_type == REQ_LOOKUP || r.req_type == REQ_REMOVE) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (table_valid[i] && table_key[i] == r.key) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        a.status = STATUS_OK;
        if (r.req_type == REQ_LOOKUP) begin
          a.found_value = table_value[hit];
        end else begin
          table_valid[hit] = 1'b0;
        end
      end
    end
    return a;
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= 1500 && cycle_count < 3500) begin
      return 1'b0;
    end
    return $urandom_range(99) < 15;
  endfunction

  task automatic queue_request(input logic [REQ_W-1:0] t, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
    request_t r;
    r.req_type = t;
    r.key = k;
    r.value = v;
    pending_requests = {pending_requests, r};
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_probe_key_value_table regression: fail");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    request_t r;
    answer_t  a;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || in_req.ready) begin
      if (in_req.valid) begin
        r.req_type = in_req.req_type;
        r.key = in_req.key;
        r.value = in_req.value;
        a = apply_request(r);
        expected_answers = {expected_answers, a};
      end
      if (pending_requests.size() > 0 && !idle_now()) begin
        r = pending_requests.pop_front();
        in_req.valid <= 1'b1;
        in_req.req_type <= r.req_type;
        in_req.key <= r.key;
        in_req.value <= r.value;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected response status %0d found_value %h", $time,
                   out_rsp.status, out_rsp.found_value);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (out_rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_rsp.status);
            errors++;
          end
          if (out_rsp.found_value !== want.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time, want.found_value,
                     out_rsp.found_value);
            errors++;
          end
        end
      end
      out_rsp.ready <= !idle_now();
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool[POOL_KEYS];
    logic [KEY_W-1:0] k;
    int               pick;
    rst_n = 1'b0;

    // fill every slot first: wrap, duplicate key, collision chain
    queue_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(REQ_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    for (int i = 0; i < TABLE_SLOTS - 3; i++) begin
      queue_request(REQ_INSERT, 32'(16 * i + 2), $urandom);
    end
    queue_request(REQ_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, $urandom);
    queue_request(REQ_REMOVE, 32'hFFFF_FFFF, $urandom);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, $urandom);
    queue_request(REQ_LOOKUP, 32'h8000_0000, $urandom);
    queue_request(REQ_REMOVE, 32'h8000_0000, $urandom);
    queue_request(REQ_UNUSED, 32'h0000_0000, $urandom);
    queue_request(REQ_LOOKUP, 32'h0000_0000, $urandom);
    queue_request(REQ_REMOVE, 32'h0000_0000, $urandom);
    queue_request(REQ_INSERT, 32'h7FFF_FFF0, 32'h8000_0001);

    for (int i = 0; i < POOL_KEYS; i++) begin
      key_pool[i] = $urandom;
    end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_KEYS - 1)] : $urandom;
      pick = $urandom_range(99);
      if (pick < 35) begin
        queue_request(REQ_INSERT, k, $urandom);
      end else if (pick < 65) begin
        queue_request(REQ_LOOKUP, k, $urandom);
      end else if (pick < 95) begin
        queue_request(REQ_REMOVE, k, $urandom);
      end else begin
        queue_request(REQ_UNUSED, k, $urandom);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_req.valid || expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * TABLE_SLOTS) @(posedge clk);

    if (errors == 0) begin
      $display("linear_probe_key_value_table regression: pass");
    end else begin
      $display("linear_probe_key_value_table regression: fail");
    end
    $finish;
  end

endmodule
